// ===== rtl/palette_integer_upscaler_top_macros.svh =====
`ifndef PALETTE_INTEGER_UPSCALER_TOP_MACROS_SVH
`define PALETTE_INTEGER_UPSCALER_TOP_MACROS_SVH

// same-cycle implication
`define PALUP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("palette upscaler check failed");

// next-cycle implication
`define PALUP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("palette upscaler check failed");

`endif

// ===== rtl/palup_pkg.sv =====
package palup_pkg;

    localparam logic [10:0] SRC_WIDTH      = 11'd320;
    localparam logic [9:0]  SRC_HEIGHT     = 10'd200;
    localparam logic [10:0] MAX_OUT_WIDTH  = 11'd1280;
    localparam logic [9:0]  MAX_OUT_HEIGHT = 10'd720;
    localparam logic [1:0]  MAX_SCALE      = 2'd3;
    localparam logic [7:0]  ALPHA_OPAQUE   = 8'hFF;
    localparam int          Q_DEPTH        = 4;
    localparam int          Q_AW           = 2;

    typedef enum logic {
        OP_PAL_WRITE = 1'b0,
        OP_DRAW      = 1'b1
    } t_op;

    typedef enum logic {
        CFG_FB_WIDTH  = 1'b0,
        CFG_FB_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [8:0]  sx;
        logic [7:0]  sy;
        logic [23:0] rgb;
    } t_pix;

    typedef struct packed {
        logic        draw;
        logic [1:0]  scale;
        logic [10:0] off_x;
        logic [9:0]  off_y;
        logic [10:0] fb_w;
        logic [9:0]  fb_h;
    } t_geom;

endpackage

// ===== rtl/palup_ram.sv =====
module palup_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/palup_front.sv =====
module palup_front #(
    parameter int PAL_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic              i_opcode,
    input  logic [7:0]        i_color_index,
    input  logic [7:0]        i_red,
    input  logic [7:0]        i_green,
    input  logic [7:0]        i_blue,
    input  logic [8:0]        i_src_x,
    input  logic [7:0]        i_src_y,
    input  logic              i_q_afull,
    output logic              o_q_push,
    output palup_pkg::t_pix   o_q_data
);

    localparam int          AW       = $clog2(PAL_DEPTH);
    localparam int unsigned WRAP_MUL = (65536 + PAL_DEPTH - 1) / PAL_DEPTH;

    // remainder by the palette depth through a reciprocal multiply
    function automatic logic [AW-1:0] f_wrap(input logic [7:0] idx);
        logic [23:0] prod;
        logic [7:0]  quo;
        logic [15:0] quo_d;
        logic [7:0]  diff;
        prod  = 24'(idx) * 24'(WRAP_MUL);
        quo   = prod[23:16];
        quo_d = 16'(quo) * 16'(PAL_DEPTH);
        diff  = idx - quo_d[7:0];
        return diff[AW-1:0];
    endfunction

    logic          w_accept;
    logic          w_is_draw;
    logic [AW-1:0] w_idx;
    logic [23:0]   w_rdata;
    logic          r_pend_v;
    logic [8:0]    r_pend_sx;
    logic [7:0]    r_pend_sy;

    assign o_full    = i_q_afull;
    assign w_accept  = i_push && !o_full;
    assign w_is_draw = (palup_pkg::t_op'(i_opcode) == palup_pkg::OP_DRAW);
    assign w_idx     = f_wrap(i_color_index);

    palup_ram #(
        .WIDTH (24),
        .DEPTH (PAL_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_accept && !w_is_draw),
        .i_waddr (w_idx),
        .i_wdata ({i_red, i_green, i_blue}),
        .i_raddr (w_idx),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else begin
            r_pend_v <= w_accept && w_is_draw;
        end
        r_pend_sx <= i_src_x;
        r_pend_sy <= i_src_y;
    end

    assign o_q_push    = r_pend_v;
    assign o_q_data.sx  = r_pend_sx;
    assign o_q_data.sy  = r_pend_sy;
    assign o_q_data.rgb = w_rdata;

endmodule

// ===== rtl/palup_fifo.sv =====
module palup_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  palup_pkg::t_pix i_data,
    output logic            o_afull,
    output logic            o_full,
    output logic            o_valid,
    output palup_pkg::t_pix o_data,
    input  logic            i_pop
);

    localparam int QD = palup_pkg::Q_DEPTH;
    localparam int QA = palup_pkg::Q_AW;

    palup_pkg::t_pix r_mem [QD];
    logic [QA-1:0]   r_wp;
    logic [QA-1:0]   r_rp;
    logic [QA:0]     r_count;
    logic            w_do_push;
    logic            w_do_pop;

    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (w_do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (QA+1)'(QD));
    assign o_afull = (r_count >= (QA+1)'(QD - 1));
    assign o_data  = r_mem[r_rp];

endmodule

// ===== rtl/palup_back.sv =====
module palup_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  palup_pkg::t_geom i_geom,
    input  logic             i_q_valid,
    input  palup_pkg::t_pix  i_q_data,
    output logic             o_q_pop,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [10:0]      o_out_x,
    output logic [9:0]       o_out_y,
    output logic [31:0]      o_argb,
    output logic             o_last
);

    // address stage
    logic        r_a_v;
    logic [11:0] r_a_x0;
    logic [11:0] r_a_y0;
    logic [23:0] r_a_rgb;
    logic [10:0] w_mx;
    logic [9:0]  w_my;

    // clip at hand-over to the emitter
    logic [11:0] w_remx;
    logic [11:0] w_remy;
    logic [1:0]  w_nx;
    logic [1:0]  w_ny;
    logic        w_a_work;
    logic        w_a_take;

    // emitter
    logic        r_e_v;
    logic [11:0] r_e_x0;
    logic [11:0] r_e_y0;
    logic [1:0]  r_e_nx;
    logic [1:0]  r_e_ny;
    logic [1:0]  r_e_dx;
    logic [1:0]  r_e_dy;
    logic [23:0] r_e_rgb;
    logic        w_e_adv;
    logic        w_e_row_end;
    logic        w_e_last;
    logic        w_e_free;

    // output register
    logic        r_o_v;
    logic [10:0] r_o_x;
    logic [9:0]  r_o_y;
    logic [23:0] r_o_rgb;
    logic        r_o_last;

    assign w_mx = 11'(i_q_data.sx) * 11'(i_geom.scale);
    assign w_my = 10'(i_q_data.sy) * 10'(i_geom.scale);

    assign w_remx = 12'(i_geom.fb_w) - r_a_x0;
    assign w_remy = 12'(i_geom.fb_h) - r_a_y0;

    always_comb begin
        if (r_a_x0 >= 12'(i_geom.fb_w)) begin
            w_nx = 2'd0;
        end else if (w_remx >= 12'(i_geom.scale)) begin
            w_nx = i_geom.scale;
        end else begin
            w_nx = w_remx[1:0];
        end
        if (r_a_y0 >= 12'(i_geom.fb_h)) begin
            w_ny = 2'd0;
        end else if (w_remy >= 12'(i_geom.scale)) begin
            w_ny = i_geom.scale;
        end else begin
            w_ny = w_remy[1:0];
        end
    end

    assign w_a_work    = i_geom.draw && (w_nx != 2'd0) && (w_ny != 2'd0);
    assign w_e_adv     = r_e_v && (!r_o_v || i_pop);
    assign w_e_row_end = (r_e_dx == r_e_nx - 2'd1);
    assign w_e_last    = w_e_row_end && (r_e_dy == r_e_ny - 2'd1);
    assign w_e_free    = !r_e_v || (w_e_adv && w_e_last);
    assign w_a_take    = r_a_v && w_e_free;
    assign o_q_pop     = i_q_valid && (!r_a_v || w_a_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (o_q_pop) begin
            r_a_v <= 1'b1;
        end else if (w_a_take) begin
            r_a_v <= 1'b0;
        end
        if (o_q_pop) begin
            r_a_x0  <= 12'(i_geom.off_x) + 12'(w_mx);
            r_a_y0  <= 12'(i_geom.off_y) + 12'(w_my);
            r_a_rgb <= i_q_data.rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v  <= 1'b0;
            r_e_dx <= 2'd0;
            r_e_dy <= 2'd0;
        end else if (w_a_take && w_a_work) begin
            r_e_v  <= 1'b1;
            r_e_dx <= 2'd0;
            r_e_dy <= 2'd0;
        end else if (w_e_adv && w_e_last) begin
            r_e_v <= 1'b0;
        end else if (w_e_adv) begin
            if (w_e_row_end) begin
                r_e_dx <= 2'd0;
                r_e_dy <= r_e_dy + 2'd1;
            end else begin
                r_e_dx <= r_e_dx + 2'd1;
            end
        end
        if (w_a_take && w_a_work) begin
            r_e_x0  <= r_a_x0;
            r_e_y0  <= r_a_y0;
            r_e_nx  <= w_nx;
            r_e_ny  <= w_ny;
            r_e_rgb <= r_a_rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_e_adv) begin
            r_o_v <= 1'b1;
        end else if (i_pop) begin
            r_o_v <= 1'b0;
        end
        if (w_e_adv) begin
            r_o_x    <= 11'(r_e_x0 + 12'(r_e_dx));
            r_o_y    <= 10'(r_e_y0 + 12'(r_e_dy));
            r_o_rgb  <= r_e_rgb;
            r_o_last <= w_e_last;
        end
    end

    assign o_empty = !r_o_v;
    assign o_out_x = r_o_x;
    assign o_out_y = r_o_y;
    assign o_argb  = {palup_pkg::ALPHA_OPAQUE, r_o_rgb};
    assign o_last  = r_o_last;

endmodule

// ===== rtl/palette_integer_upscaler_top.sv =====
// Palette lookup and integer upscaler. Push palette writes (opcode 0) and source pixels
// (opcode 1); each pixel comes out as up to scale x scale framebuffer writes, row by row,
// left to right, with last set on the final one. Writes that fall outside the framebuffer
// are dropped, and a framebuffer smaller than the source frame produces no writes. The
// output gives at most one write per cycle and stalls while a held write is not popped.
// A pixel gives up to 1, 4 or 9 writes at scale 1, 2 or 3. The single write emitter
// behind the input queue sets the output rate; a palette write uses one push, no output.
// A pixel passes the palette read, queue, address, emitter and output registers.
// The palette is a 256 x 24 synchronous RAM with no reset; load every entry before it is
// used. Write fb_width and fb_height only while the block is idle.
`include "palette_integer_upscaler_top_macros.svh"

module palette_integer_upscaler_top #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_opcode,
    input  logic [7:0]  i_color_index,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [8:0]  i_src_x,
    input  logic [7:0]  i_src_y,
    output logic        empty,
    input  logic        pop,
    output logic [10:0] o_out_x,
    output logic [9:0]  o_out_y,
    output logic [31:0] o_argb,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    logic [10:0]       r_fb_w;
    logic [9:0]        r_fb_h;
    palup_pkg::t_geom  r_geom;
    palup_pkg::t_geom  n_geom;
    logic [1:0]        w_sc_x;
    logic [1:0]        w_sc_y;
    logic [10:0]       w_span_x;
    logic [9:0]        w_span_y;
    logic              w_fb_in_range;

    logic              w_q_push;
    palup_pkg::t_pix   w_q_wdata;
    logic              w_q_afull;
    logic              w_q_full;
    logic              w_q_valid;
    palup_pkg::t_pix   w_q_rdata;
    logic              w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_w <= palup_pkg::MAX_OUT_WIDTH;
            r_fb_h <= palup_pkg::MAX_OUT_HEIGHT;
        end else if (i_cfg_we) begin
            case (palup_pkg::t_cfg_reg'(i_cfg_index))
                palup_pkg::CFG_FB_WIDTH: begin
                    r_fb_w <= (i_cfg_data > palup_pkg::MAX_OUT_WIDTH)
                            ? palup_pkg::MAX_OUT_WIDTH : i_cfg_data;
                end
                palup_pkg::CFG_FB_HEIGHT: begin
                    r_fb_h <= (i_cfg_data[9:0] > palup_pkg::MAX_OUT_HEIGHT)
                            ? palup_pkg::MAX_OUT_HEIGHT : i_cfg_data[9:0];
                end
                default: begin
                    r_fb_w <= r_fb_w;
                end
            endcase
        end
    end

    always_comb begin
        if (r_fb_w >= 11'(3 * palup_pkg::SRC_WIDTH)) begin
            w_sc_x = palup_pkg::MAX_SCALE;
        end else if (r_fb_w >= 11'(2 * palup_pkg::SRC_WIDTH)) begin
            w_sc_x = 2'd2;
        end else begin
            w_sc_x = 2'd1;
        end
        if (r_fb_h >= 10'(3 * palup_pkg::SRC_HEIGHT)) begin
            w_sc_y = palup_pkg::MAX_SCALE;
        end else if (r_fb_h >= 10'(2 * palup_pkg::SRC_HEIGHT)) begin
            w_sc_y = 2'd2;
        end else begin
            w_sc_y = 2'd1;
        end
        n_geom.scale = (w_sc_x < w_sc_y) ? w_sc_x : w_sc_y;
        case (n_geom.scale)
            2'd3: begin
                w_span_x = 11'(3 * palup_pkg::SRC_WIDTH);
                w_span_y = 10'(3 * palup_pkg::SRC_HEIGHT);
            end
            2'd2: begin
                w_span_x = 11'(2 * palup_pkg::SRC_WIDTH);
                w_span_y = 10'(2 * palup_pkg::SRC_HEIGHT);
            end
            default: begin
                w_span_x = palup_pkg::SRC_WIDTH;
                w_span_y = palup_pkg::SRC_HEIGHT;
            end
        endcase
        n_geom.draw  = (r_fb_w >= palup_pkg::SRC_WIDTH) && (r_fb_h >= palup_pkg::SRC_HEIGHT);
        n_geom.off_x = (r_fb_w - w_span_x) >> 1;
        n_geom.off_y = (r_fb_h - w_span_y) >> 1;
        n_geom.fb_w  = r_fb_w;
        n_geom.fb_h  = r_fb_h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom <= '0;
        end else begin
            r_geom <= n_geom;
        end
    end

    palup_front #(
        .PAL_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_opcode      (i_opcode),
        .i_color_index (i_color_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_src_x       (i_src_x),
        .i_src_y       (i_src_y),
        .i_q_afull     (w_q_afull),
        .o_q_push      (w_q_push),
        .o_q_data      (w_q_wdata)
    );

    palup_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_afull (w_q_afull),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_rdata),
        .i_pop   (w_q_pop)
    );

    palup_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (r_geom),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_rdata),
        .o_q_pop   (w_q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_out_x   (o_out_x),
        .o_out_y   (o_out_y),
        .o_argb    (o_argb),
        .o_last    (o_last)
    );

    assign w_fb_in_range = (r_fb_w <= palup_pkg::MAX_OUT_WIDTH)
                        && (r_fb_h <= palup_pkg::MAX_OUT_HEIGHT);

    `PALUP_ASSERT_NOW(a_queue_no_overflow, w_q_push, !w_q_full)
    `PALUP_ASSERT_NOW(a_draw_has_scale, r_geom.draw, r_geom.scale != 2'd0)
    `PALUP_ASSERT_NEXT(a_cfg_saturates, i_cfg_we, w_fb_in_range)

endmodule

// ===== tb/palette_integer_upscaler_top_test.sv =====
module palette_integer_upscaler_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        palup_pkg::t_op op;
        logic [7:0]     color_index;
        logic [7:0]     red;
        logic [7:0]     green;
        logic [7:0]     blue;
        logic [8:0]     src_x;
        logic [7:0]     src_y;
    } t_pix_request;

    typedef struct packed {
        logic [10:0] x;
        logic [9:0]  y;
        logic [31:0] argb;
        logic        last;
    } t_fb_write;

    class upscale_scoreboard;
        logic [23:0] palette [256];
        logic [10:0] fb_w;
        logic [9:0]  fb_h;
        t_fb_write   pending_writes[$];
        int unsigned mismatches;

        function new();
            fb_w = palup_pkg::MAX_OUT_WIDTH;
            fb_h = palup_pkg::MAX_OUT_HEIGHT;
            mismatches = 0;
        endfunction

        function void flag_error(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%s", msg);
            end
        endfunction

        function void set_register(palup_pkg::t_cfg_reg r, logic [10:0] d);
            if (r == palup_pkg::CFG_FB_WIDTH) begin
                fb_w = (d > palup_pkg::MAX_OUT_WIDTH) ? palup_pkg::MAX_OUT_WIDTH : d;
            end else begin
                fb_h = (d[9:0] > palup_pkg::MAX_OUT_HEIGHT) ? palup_pkg::MAX_OUT_HEIGHT
                                                            : d[9:0];
            end
        endfunction

        // palette writes fill the table; a draw queues its clipped square
        function void note_request(t_pix_request r);
            int unsigned w, h, sw, sh, scale, sxs, sys, off_x, off_y, px, py;
            t_fb_write   wr;
            t_fb_write   square[$];
            w = 32'(fb_w);
            h = 32'(fb_h);
            sw = 32'(palup_pkg::SRC_WIDTH);
            sh = 32'(palup_pkg::SRC_HEIGHT);
            if (r.op == palup_pkg::OP_PAL_WRITE) begin
                palette[r.color_index] = {r.red, r.green, r.blue};
                return;
            end
            if (w == 0 || h == 0 || w < sw || h < sh) begin
                return;
            end
            sxs = w / sw;
            sys = h / sh;
            scale = (sxs < sys) ? sxs : sys;
            if (scale == 0) begin
                scale = 1;
            end
            if (scale > 32'(palup_pkg::MAX_SCALE)) begin
                scale = 32'(palup_pkg::MAX_SCALE);
            end
            off_x = (w - sw * scale) / 2;
            off_y = (h - sh * scale) / 2;
            for (int unsigned dy = 0; dy < scale; dy++) begin
                py = off_y + 32'(r.src_y) * scale + dy;
                if (py >= h) begin
                    continue;
                end
                for (int unsigned dx = 0; dx < scale; dx++) begin
                    px = off_x + 32'(r.src_x) * scale + dx;
                    if (px >= w) begin
                        continue;
                    end
                    wr.x = px[10:0];
                    wr.y = py[9:0];
                    wr.argb = {palup_pkg::ALPHA_OPAQUE, palette[r.color_index]};
                    wr.last = 1'b0;
                    square.push_back(wr);
                end
            end
            if (square.size() > 0) begin
                square[square.size() - 1].last = 1'b1;
            end
            foreach (square[i]) begin
                pending_writes.push_back(square[i]);
            end
        endfunction

        function void check_write(t_fb_write got);
            t_fb_write want;
            if (pending_writes.size() == 0) begin
                flag_error($sformatf("unexpected write x=%0d y=%0d argb=%08h last=%0d",
                                     got.x, got.y, got.argb, got.last));
                return;
            end
            want = pending_writes.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.argb !== want.argb
                    || got.last !== want.last) begin
                flag_error($sformatf({"write mismatch: expected x=%0d y=%0d argb=%08h ",
                                      "last=%0d, got x=%0d y=%0d argb=%08h last=%0d"},
                                     want.x, want.y, want.argb, want.last,
                                     got.x, got.y, got.argb, got.last));
            end
        endfunction

        function void check_drained();
            if (pending_writes.size() != 0) begin
                flag_error($sformatf("%0d writes never arrived", pending_writes.size()));
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_opcode = palup_pkg::OP_PAL_WRITE;
    logic [7:0]  i_color_index = '0;
    logic [7:0]  i_red = '0;
    logic [7:0]  i_green = '0;
    logic [7:0]  i_blue = '0;
    logic [8:0]  i_src_x = '0;
    logic [7:0]  i_src_y = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [10:0] o_out_x;
    logic [9:0]  o_out_y;
    logic [31:0] o_argb;
    logic        o_last;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = palup_pkg::CFG_FB_WIDTH;
    logic [10:0] i_cfg_data = '0;

    upscale_scoreboard sb;
    bit                no_idle = 1'b0;
    bit                loaded_mask [256];
    logic [7:0]        loaded_idx[$];
    int unsigned       cycle_count = 0;

    palette_integer_upscaler_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_opcode      (i_opcode),
        .i_color_index (i_color_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_src_x       (i_src_x),
        .i_src_y       (i_src_y),
        .empty         (empty),
        .pop           (pop),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_argb        (o_argb),
        .o_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_pix_request make_pal(logic [7:0] idx, logic [7:0] r,
                                              logic [7:0] g, logic [7:0] b);
        t_pix_request req;
        req.op = palup_pkg::OP_PAL_WRITE;
        req.color_index = idx;
        req.red = r;
        req.green = g;
        req.blue = b;
        req.src_x = 9'($urandom_range(0, 511));
        req.src_y = 8'($urandom_range(0, 255));
        if (!loaded_mask[idx]) begin
            loaded_mask[idx] = 1'b1;
            loaded_idx.push_back(idx);
        end
        return req;
    endfunction

    function automatic t_pix_request make_draw(logic [7:0] idx, logic [8:0] sx,
                                               logic [7:0] sy);
        t_pix_request req;
        req.op = palup_pkg::OP_DRAW;
        req.color_index = idx;
        req.red = 8'($urandom_range(0, 255));
        req.green = 8'($urandom_range(0, 255));
        req.blue = 8'($urandom_range(0, 255));
        req.src_x = sx;
        req.src_y = sy;
        return req;
    endfunction

    // draws only read palette entries that were loaded; a few fall outside the frame
    function automatic t_pix_request random_request();
        logic [8:0] sx;
        logic [7:0] sy;
        if (loaded_idx.size() == 0 || $urandom_range(0, 3) == 0) begin
            return make_pal(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        sx = ($urandom_range(0, 6) == 0) ? 9'($urandom_range(0, 511))
                                         : 9'($urandom_range(0, 319));
        sy = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 199));
        return make_draw(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)], sx, sy);
    endfunction

    task automatic send_request(t_pix_request req);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap != 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push = 1'b1;
        i_opcode = req.op;
        i_color_index = req.color_index;
        i_red = req.red;
        i_green = req.green;
        i_blue = req.blue;
        i_src_x = req.src_x;
        i_src_y = req.src_y;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_request(req);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        push = 1'b0;
        while (sb.pending_writes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(palup_pkg::t_cfg_reg r, logic [10:0] d);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = r;
        i_cfg_data = d;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_register(r, d);
    endtask

    task automatic run_phase(logic [10:0] w, logic [10:0] h, int n, bit steady);
        if ($urandom_range(0, 1) == 0) begin
            write_register(palup_pkg::CFG_FB_WIDTH, w);
            write_register(palup_pkg::CFG_FB_HEIGHT, h);
        end else begin
            write_register(palup_pkg::CFG_FB_HEIGHT, h);
            write_register(palup_pkg::CFG_FB_WIDTH, w);
        end
        no_idle = steady;
        repeat (n) begin
            send_request(random_request());
            if ($urandom_range(0, 39) == 0) begin
                wait_idle();
            end
        end
        wait_idle();
    endtask

    // result side: random stalls before each pop, none while no_idle is set
    initial begin
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 15);
            @(negedge i_clk);
            if (stall == 0) begin
                pop = 1'b1;
            end else begin
                pop = 1'b0;
                repeat (stall) @(negedge i_clk);
                pop = 1'b1;
            end
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            sb.check_write({o_out_x, o_out_y, o_argb, o_last});
        end
    end

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset geometry: 1280x720, scale 3, centered at 160,60
        send_request(make_pal(8'h00, 8'h00, 8'h00, 8'h00));
        send_request(make_pal(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_request(make_pal(8'h55, 8'h12, 8'h34, 8'h56));
        send_request(make_pal(8'hAA, 8'hA5, 8'h5A, 8'hC3));
        send_request(make_draw(8'h00, 9'd0, 8'd0));
        send_request(make_draw(8'hFF, 9'd319, 8'd199));
        send_request(make_draw(8'h55, 9'd0, 8'd199));
        send_request(make_draw(8'hAA, 9'd319, 8'd0));
        // right edge clips part of the square, then all of it
        send_request(make_draw(8'h55, 9'd373, 8'd10));
        send_request(make_draw(8'hAA, 9'd374, 8'd10));
        send_request(make_draw(8'hFF, 9'd10, 8'd219));
        send_request(make_draw(8'hFF, 9'd10, 8'd220));
        send_request(make_draw(8'h00, 9'd511, 8'd255));
        // overwrite an entry and read it right away
        send_request(make_pal(8'h00, 8'hC3, 8'h3C, 8'h81));
        send_request(make_draw(8'h00, 9'd100, 8'd100));
        send_request(make_draw(8'hFF, 9'd256, 8'd128));
        wait_idle();

        run_phase(11'd640, 11'd400, 50, 1'b0);
        run_phase(11'd320, 11'd200, 50, 1'b1);
        run_phase(11'd0, 11'd720, 12, 1'b0);
        run_phase(11'd1280, 11'd0, 12, 1'b0);
        run_phase(11'd319, 11'd200, 12, 1'b1);
        run_phase(11'h7FF, 11'h7FF, 50, 1'b0);
        run_phase(11'd1000, 11'd650, 50, 1'b0);
        run_phase(11'd700, 11'd500, 50, 1'b1);
        run_phase(11'd1280, 11'd400, 50, 1'b0);
        run_phase(11'd321, 11'd719, 50, 1'b0);
        run_phase(11'd330, 11'd210, 45, 1'b1);
        run_phase(11'd1280, 11'd720, 20, 1'b0);

        sb.check_drained();
        if (sb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/palup_pkg.sv
rtl/palup_ram.sv
rtl/palup_front.sv
rtl/palup_fifo.sv
rtl/palup_back.sv
rtl/palette_integer_upscaler_top.sv
tb/palette_integer_upscaler_top_test.sv
